/* rtl/core/prr_pkg.sv */
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types and constants of the polyphase rational resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int MAX_PHASES_DEF   = 64;
    localparam int MAX_TAPS_DEF     = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 16;
    localparam int MAX_DOWN         = 64;
    localparam int RATIO_WIDTH      = 7;
    localparam int FIELD_WIDTH      = 6;
    localparam int QUEUE_DEPTH      = 2;

    // input actions
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_COEF = 1'b1;

    // register indexes
    localparam logic [1:0] REG_UP   = 2'd0;
    localparam logic [1:0] REG_DOWN = 2'd1;
    localparam logic [1:0] REG_TAPS = 2'd2;

    // back end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } mac_state_t;

endpackage

/* rtl/core/prr_front.sv */
// ----------------------------------------------------------------------------
// prr_front
// Accepts items, drives coefficient writes and queues pushes.
// ----------------------------------------------------------------------------
module prr_front
    import prr_pkg::*;
#(
    parameter int MAX_PHASES   = MAX_PHASES_DEF,
    parameter int MAX_TAPS     = MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
    localparam int PW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1,
    localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
    input  logic [FIELD_WIDTH-1:0]         coef_phase,
    input  logic [FIELD_WIDTH-1:0]         coef_tap,
    input  logic signed [COEF_WIDTH-1:0]   coef_value,
    // back end has no run in progress
    input  logic                           idle,
    // coefficient write port
    output logic                           cw_en,
    output logic [PW+TW-1:0]               cw_addr,
    output logic signed [COEF_WIDTH-1:0]   cw_data,
    // queued pushes
    output logic                           q_valid,
    input  logic                           q_take,
    output logic signed [SAMPLE_WIDTH-1:0] q_i,
    output logic signed [SAMPLE_WIDTH-1:0] q_q
);

    logic signed [SAMPLE_WIDTH-1:0] qi_reg [QUEUE_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] qq_reg [QUEUE_DEPTH];
    logic                           rd_reg, rd_next;
    logic                           wr_reg, wr_next;
    logic [1:0]                     cnt_reg, cnt_next;
    logic                           accept;
    logic                           push;
    logic                           addr_ok;

    // a push needs a free queue slot, a coefficient write waits until
    // every earlier push has been fully worked off
    assign in_ready = (action == ACT_COEF) ? ((cnt_reg == 2'd0) && idle)
                                           : (cnt_reg != 2'(QUEUE_DEPTH));
    assign accept   = in_valid && in_ready;
    assign push     = accept && (action == ACT_PUSH);

    // coefficient write, out of range addresses dropped
    assign addr_ok = (32'(coef_phase) < 32'(MAX_PHASES)) && (32'(coef_tap) < 32'(MAX_TAPS));
    assign cw_en   = accept && (action == ACT_COEF) && addr_ok;
    assign cw_addr = {PW'(coef_phase), TW'(coef_tap)};
    assign cw_data = coef_value;

    // queue pointers
    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = q_take ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qi_reg[wr_reg] <= sample_i;
            qq_reg[wr_reg] <= sample_q;
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_i     = qi_reg[rd_reg];
    assign q_q     = qq_reg[rd_reg];

endmodule

/* rtl/core/prr_back.sv */
// ----------------------------------------------------------------------------
// prr_back
// Delay line, coefficient memory and shared complex multiply-accumulate.
// ----------------------------------------------------------------------------
module prr_back
    import prr_pkg::*;
#(
    parameter int MAX_PHASES   = MAX_PHASES_DEF,
    parameter int MAX_TAPS     = MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
    localparam int PW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1,
    localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [RATIO_WIDTH-1:0]         up_ratio,
    input  logic [RATIO_WIDTH-1:0]         down_ratio,
    input  logic [RATIO_WIDTH-1:0]         taps_per_phase,
    input  logic                           cw_en,
    input  logic [PW+TW-1:0]               cw_addr,
    input  logic signed [COEF_WIDTH-1:0]   cw_data,
    input  logic                           q_valid,
    output logic                           q_take,
    input  logic signed [SAMPLE_WIDTH-1:0] q_i,
    input  logic signed [SAMPLE_WIDTH-1:0] q_q,
    output logic                           idle,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_i,
    output logic signed [SAMPLE_WIDTH-1:0] out_q,
    output logic                           last
);

    localparam int PRODW = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACCW  = PRODW + TW + 1;
    localparam int FRAC  = COEF_WIDTH - 1;
    localparam int AW    = RATIO_WIDTH + 2;
    localparam int KW    = TW + 1;

    logic signed [COEF_WIDTH-1:0]   cmem [MAX_PHASES*MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_i_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_q_mem [MAX_TAPS];

    mac_state_t                     state_reg, state_next;
    logic [AW-1:0]                  phase_reg, phase_next;
    logic [KW-1:0]                  k_reg, k_next;
    logic [TW-1:0]                  head_reg;
    logic [KW-1:0]                  fill_reg;
    logic                           ld_reg;
    logic signed [COEF_WIDTH-1:0]   c_reg;
    logic signed [SAMPLE_WIDTH-1:0] hi_reg, hq_reg;
    logic                           hlive_reg;
    logic signed [PRODW-1:0]        pi_reg, pq_reg;
    logic                           pv_reg;
    logic signed [ACCW-1:0]         acc_i_reg, acc_q_reg;
    logic                           ovalid_reg;
    logic signed [SAMPLE_WIDTH-1:0] oi_reg, oq_reg;
    logic                           olast_reg;

    logic [AW-1:0]                  u_eff, d_eff;
    logic [KW-1:0]                  taps_eff;
    logic                           start, issue, finish;
    logic [AW-1:0]                  next_acc;
    logic [PW-1:0]                  phase_idx;
    logic [TW-1:0]                  head_inc;
    logic [TW-1:0]                  tap_addr;

    // saturate the ratio registers
    always_comb
    begin
        u_eff = AW'(up_ratio);
        if (u_eff == '0)
            u_eff = AW'(1);
        if (32'(u_eff) > MAX_PHASES)
            u_eff = AW'(MAX_PHASES);
        d_eff = AW'(down_ratio);
        if (d_eff == '0)
            d_eff = AW'(1);
        if (32'(d_eff) > MAX_DOWN)
            d_eff = AW'(MAX_DOWN);
        taps_eff = (32'(taps_per_phase) > MAX_TAPS) ? KW'(MAX_TAPS) : KW'(taps_per_phase);
    end

    assign phase_idx = PW'(phase_reg);
    assign next_acc  = phase_reg + d_eff;

    // circular delay line: newest sample at head, tap k sits k slots back
    assign head_inc = (32'(head_reg) == MAX_TAPS - 1) ? '0 : head_reg + TW'(1);
    assign tap_addr = (TW'(k_reg) <= head_reg) ? head_reg - TW'(k_reg)
                                               : head_reg + TW'(MAX_TAPS) - TW'(k_reg);

    // round to nearest, ties up, then saturate
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(logic signed [ACCW-1:0] a);
        logic signed [ACCW-1:0] r;
        logic signed [ACCW-1:0] hi;
        logic signed [ACCW-1:0] lo;
        r  = (a + (ACCW'(1) <<< (FRAC - 1))) >>> FRAC;
        hi = ACCW'((64'(1) << (SAMPLE_WIDTH - 1)) - 64'(1));
        lo = -hi - ACCW'(1);
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    assign start  = (state_reg == ST_IDLE) && q_valid;
    assign q_take = start;
    assign idle   = (state_reg == ST_IDLE);
    assign issue  = (state_reg == ST_MAC);
    assign finish = (state_reg == ST_OUT) && (!ovalid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    k_next = '0;
                    if (phase_reg < u_eff)
                        state_next = (taps_eff == '0) ? ST_DRAIN : ST_MAC;
                    else
                        phase_next = phase_reg - u_eff;
                end
            end
            ST_MAC:
            begin
                k_next = k_reg + KW'(1);
                if (k_reg + KW'(1) >= taps_eff)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!ld_reg && !pv_reg)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (finish)
                begin
                    k_next = '0;
                    if (next_acc < u_eff)
                    begin
                        phase_next = next_acc;
                        state_next = (taps_eff == '0) ? ST_DRAIN : ST_MAC;
                    end
                    else
                    begin
                        phase_next = next_acc - u_eff;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= '0;
            k_reg      <= '0;
            ld_reg     <= 1'b0;
            pv_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            head_reg   <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            ld_reg    <= issue;
            pv_reg    <= ld_reg;
            if (finish)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            // advance the delay line on each dequeued push
            if (start)
            begin
                head_reg <= head_inc;
                if (32'(fill_reg) < MAX_TAPS)
                    fill_reg <= fill_reg + KW'(1);
            end
        end
    end

    // delay line and coefficient memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cw_en)
            cmem[cw_addr] <= cw_data;
        if (start)
        begin
            hist_i_mem[head_inc] <= q_i;
            hist_q_mem[head_inc] <= q_q;
        end
        c_reg     <= cmem[{phase_idx, TW'(k_reg)}];
        hi_reg    <= hist_i_mem[tap_addr];
        hq_reg    <= hist_q_mem[tap_addr];
        hlive_reg <= (k_reg < fill_reg);
    end

    // multiply then accumulate, taps not yet filled since reset count as zero
    always_ff @(posedge clk)
    begin
        pi_reg <= c_reg * (hlive_reg ? hi_reg : SAMPLE_WIDTH'(0));
        pq_reg <= c_reg * (hlive_reg ? hq_reg : SAMPLE_WIDTH'(0));
        if ((issue && k_reg == '0) || (state_reg == ST_DRAIN && taps_eff == '0))
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_i_reg <= acc_i_reg + ACCW'(pi_reg);
            acc_q_reg <= acc_q_reg + ACCW'(pq_reg);
        end
        if (finish)
        begin
            oi_reg    <= round_sat(acc_i_reg);
            oq_reg    <= round_sat(acc_q_reg);
            olast_reg <= !(next_acc < u_eff);
        end
    end

    assign out_valid = ovalid_reg;
    assign out_i     = oi_reg;
    assign out_q     = oq_reg;
    assign last      = olast_reg;

endmodule

/* rtl/core/polyphase_rational_resampler.sv */
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// Rational U/D polyphase FIR resampler for complex Q1.15 samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        sink       in_valid/in_ready     action, sample, coefficient
//  out       source     out_valid/out_ready   out_i, out_q, last
//  cfg       apb        psel/penable/pready   up, down, taps registers
//
// each output runs one multiply-accumulate per tap on the shared complex MAC,
// then memory read, multiply and drain, paid per emitted item.
// coefficient items wait until the queue and the sequencer are empty.
// pushes wait in a two-entry queue.
// reset empties the delay line, clears phase and sets up/down/taps to 2/1/3; coefficients stay unset.
// a stalled output holds the sequencer; the queue keeps taking pushes.
module polyphase_rational_resampler
    import prr_pkg::*;
#(
    parameter int MAX_PHASES   = MAX_PHASES_DEF,
    parameter int MAX_TAPS     = MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
    input  logic [FIELD_WIDTH-1:0]         coef_phase,
    input  logic [FIELD_WIDTH-1:0]         coef_tap,
    input  logic signed [COEF_WIDTH-1:0]   coef_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_i,
    output logic signed [SAMPLE_WIDTH-1:0] out_q,
    output logic                           last
);

    localparam int PW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    logic [RATIO_WIDTH-1:0]         up_reg, down_reg, taps_reg;
    logic                           wr;
    logic                           cw_en;
    logic [PW+TW-1:0]               cw_addr;
    logic signed [COEF_WIDTH-1:0]   cw_data;
    logic                           q_valid, q_take;
    logic signed [SAMPLE_WIDTH-1:0] q_i, q_q;
    logic                           back_idle;

    // register file
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= RATIO_WIDTH'(2);
            down_reg <= RATIO_WIDTH'(1);
            taps_reg <= RATIO_WIDTH'(3);
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_UP:   up_reg   <= pwdata[RATIO_WIDTH-1:0];
                REG_DOWN: down_reg <= pwdata[RATIO_WIDTH-1:0];
                REG_TAPS: taps_reg <= pwdata[RATIO_WIDTH-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_UP:   prdata = 32'(up_reg);
            REG_DOWN: prdata = 32'(down_reg);
            REG_TAPS: prdata = 32'(taps_reg);
            default:  prdata = '0;
        endcase
    end

    prr_front #(
        .MAX_PHASES   (MAX_PHASES),
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sample_i   (sample_i),
        .sample_q   (sample_q),
        .coef_phase (coef_phase),
        .coef_tap   (coef_tap),
        .coef_value (coef_value),
        .idle       (back_idle),
        .cw_en      (cw_en),
        .cw_addr    (cw_addr),
        .cw_data    (cw_data),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .q_i        (q_i),
        .q_q        (q_q)
    );

    prr_back #(
        .MAX_PHASES   (MAX_PHASES),
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_ratio       (up_reg),
        .down_ratio     (down_reg),
        .taps_per_phase (taps_reg),
        .cw_en          (cw_en),
        .cw_addr        (cw_addr),
        .cw_data        (cw_data),
        .q_valid        (q_valid),
        .q_take         (q_take),
        .q_i            (q_i),
        .q_q            (q_q),
        .idle           (back_idle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_i          (out_i),
        .out_q          (out_q),
        .last           (last)
    );

endmodule
